### rtl/core/hlp_pkg.sv
// ----------------------------------------------------------------------------
// hlp_pkg
// Shared types, constants and helpers for the hunk line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hlp_pkg;

    // Width of every decimal field; a value saturates at 2^VAL_W-1.
    localparam int VAL_W     = 63;
    // Four fields packed back to back, padded up to whole bytes.
    localparam int OUT_DATA_W = ((4 * VAL_W + 7) / 8) * 8;
    localparam int LEAD_LEN  = 5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [4:0] {
        PH_PREFIX      = 5'b00001,
        PH_FIELD_START = 5'b00010,
        PH_NUMBER      = 5'b00100,
        PH_TAIL        = 5'b01000,
        PH_BAD         = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_BAD_COORD = 2'd3
    } t_status;

    // Result of one multiply-by-ten-and-add step.
    typedef struct packed {
        logic             ovf;
        logic [VAL_W-1:0] value;
    } t_mac_res;

    // Expected character of the "hunk " prefix at a given position.
    function automatic logic [7:0] lead_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h68; // h
            3'd1:    c = 8'h75; // u
            3'd2:    c = 8'h6E; // n
            3'd3:    c = 8'h6B; // k
            3'd4:    c = CH_SPACE;
            default: c = 8'hFF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/hlp_digit_mac.sv
// ----------------------------------------------------------------------------
// hlp_digit_mac
// Decimal accumulate step: acc * 10 + digit, saturating at the field maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module hlp_digit_mac (
    input  wire logic [hlp_pkg::VAL_W-1:0] i_acc,
    input  wire logic [3:0]                i_digit,
    output hlp_pkg::t_mac_res              o_res
);

    localparam int EXT_W = hlp_pkg::VAL_W + 4;

    logic [EXT_W-1:0] w_acc_ext;
    logic [EXT_W-1:0] w_sum;

    // acc * 10 as (acc << 3) + (acc << 1); four guard bits hold the carry-out
    assign w_acc_ext = {4'b0000, i_acc};
    assign w_sum     = (w_acc_ext << 3) + (w_acc_ext << 1)
                     + {{(EXT_W-4){1'b0}}, i_digit};

    assign o_res.ovf   = |w_sum[EXT_W-1:hlp_pkg::VAL_W];
    assign o_res.value = o_res.ovf ? {hlp_pkg::VAL_W{1'b1}} : w_sum[hlp_pkg::VAL_W-1:0];

endmodule

`default_nettype wire

### rtl/core/hunk_line_parser.sv
// ----------------------------------------------------------------------------
// hunk_line_parser
// Byte-serial parser for "hunk <os> <oc> <ns> <nc>" lines; one result word
// per line with status and 1-based coordinates.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload                                   | Marker
//  ---------+-----+-------------------------------------------+-------------
//  s (in)   | in  | tdata[7:0] line_byte                      | tlast = EOL
//  m (out)  | out | tdata old_first,old_lines,new_first,      | tuser=status
//           |     |       new_lines (63 b each, lowest first) |
//
//  Flow   : one byte per clock while no tlast byte is held (see Stalls); a
//           byte passes through the input register, and the line result is
//           loaded into the output register as its last byte leaves the
//           input register.
//  Limit  : the x10 accumulate (one 67-bit add and carry-out check) sets the
//           register-to-register path.
//  Reset  : i_rst_n low on a clock edge clears both valid flags and returns
//           the parser to prefix matching.
//  Stalls : bytes without tlast keep flowing while a result waits; a tlast
//           byte holds in the input register until the output word is free.
//
`default_nettype none

module hunk_line_parser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,  // [7:0] line_byte
    input  wire logic                             i_s_tlast,  // end_of_line
    // result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // old_first, old_lines, new_first, new_lines, zero pad (lowest bits first)
    output logic [hlp_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    output logic [1:0]                            o_m_tuser   // [1:0] parse_status
);

    localparam int VW = hlp_pkg::VAL_W;

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eol;
    logic       w_adv;

    // A byte advances unless it closes a line and the output word is occupied.
    assign w_adv      = r_in_valid && (!r_in_eol || !o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_eol  <= i_s_tlast;
        end
    end

    // ---------------- parser state ----------------
    hlp_pkg::t_phase r_phase, n_phase, w_phase;
    logic [2:0]      r_pos,   n_pos,   w_pos;
    logic [1:0]      r_field, n_field, w_field;
    logic [VW-1:0]   r_acc,   n_acc,   w_acc;
    logic [VW-1:0]   r_fin [3];
    logic [VW-1:0]   n_fin [3];
    logic [VW-1:0]   w_fin [3];
    logic            r_ovf,   n_ovf,   w_ovf;
    logic            r_mal,   n_mal,   w_mal;

    logic              w_is_digit;
    logic [3:0]        w_digit;
    logic [7:0]        w_digit_full;
    hlp_pkg::t_mac_res w_mac;

    assign w_is_digit   = (r_in_byte >= hlp_pkg::CH_ZERO) && (r_in_byte <= hlp_pkg::CH_NINE);
    assign w_digit_full = r_in_byte - hlp_pkg::CH_ZERO;
    assign w_digit      = w_digit_full[3:0];

    hlp_digit_mac u_mac (
        .i_acc   (r_acc),
        .i_digit (w_digit),
        .o_res   (w_mac)
    );

    // Post-byte state: what the parser holds once the current byte is taken.
    always_comb begin
        w_phase = r_phase;
        w_pos   = r_pos;
        w_field = r_field;
        w_acc   = r_acc;
        w_fin   = r_fin;
        w_ovf   = r_ovf;
        w_mal   = r_mal;

        unique case (r_phase)
            hlp_pkg::PH_PREFIX: begin
                if ((r_pos < 3'(hlp_pkg::LEAD_LEN)) &&
                    (r_in_byte == hlp_pkg::lead_char(r_pos))) begin
                    w_pos = r_pos + 3'd1;
                    if (w_pos == 3'(hlp_pkg::LEAD_LEN)) begin
                        w_phase = hlp_pkg::PH_FIELD_START;
                        w_field = 2'd0;
                    end
                end else begin
                    w_mal   = 1'b1;
                    w_phase = hlp_pkg::PH_BAD;
                end
            end
            hlp_pkg::PH_FIELD_START: begin
                if (w_is_digit) begin
                    w_acc   = {{(VW-4){1'b0}}, w_digit};
                    w_phase = hlp_pkg::PH_NUMBER;
                end else begin
                    w_mal   = 1'b1;
                    w_phase = hlp_pkg::PH_BAD;
                end
            end
            hlp_pkg::PH_NUMBER: begin
                if (w_is_digit) begin
                    // saturate and flag, the line stays well-formed
                    w_acc = w_mac.value;
                    if (w_mac.ovf) begin
                        w_ovf = 1'b1;
                    end
                end else if (r_in_byte == hlp_pkg::CH_NUL) begin
                    if (r_field == 2'd3) begin
                        w_phase = hlp_pkg::PH_TAIL;
                    end else begin
                        w_mal   = 1'b1;
                        w_phase = hlp_pkg::PH_BAD;
                    end
                end else if (r_in_byte == hlp_pkg::CH_SPACE) begin
                    if (r_field == 2'd3) begin
                        w_phase = hlp_pkg::PH_TAIL;
                    end else begin
                        w_fin[r_field] = r_acc;
                        w_field        = r_field + 2'd1;
                        w_phase        = hlp_pkg::PH_FIELD_START;
                    end
                end else begin
                    w_mal   = 1'b1;
                    w_phase = hlp_pkg::PH_BAD;
                end
            end
            hlp_pkg::PH_TAIL: begin
                // ignore everything after the last field
            end
            hlp_pkg::PH_BAD: begin
                w_mal = 1'b1;
            end
            default: begin
                w_mal   = 1'b1;
                w_phase = hlp_pkg::PH_BAD;
            end
        endcase

        // NUL ends the text: only a finished last field survives it
        if ((r_in_byte == hlp_pkg::CH_NUL) && (w_phase != hlp_pkg::PH_TAIL) &&
            (w_phase != hlp_pkg::PH_NUMBER)) begin
            w_mal   = 1'b1;
            w_phase = hlp_pkg::PH_BAD;
        end
    end

    // ---------------- line result ----------------
    hlp_pkg::t_status w_status;
    logic [VW-1:0]    w_os, w_oc, w_ns, w_nc;
    logic             w_done;

    assign w_done = (w_phase == hlp_pkg::PH_TAIL) ||
                    ((w_phase == hlp_pkg::PH_NUMBER) && (w_field == 2'd3));

    always_comb begin
        w_status = hlp_pkg::ST_OK;
        w_os     = '0;
        w_oc     = '0;
        w_ns     = '0;
        w_nc     = '0;
        if (w_mal || !w_done) begin
            w_status = hlp_pkg::ST_MALFORMED;
        end else if (w_ovf) begin
            w_status = hlp_pkg::ST_OVERFLOW;
        end else if (((w_fin[0] == '0) && (w_fin[1] != '0)) ||
                     ((w_fin[2] == '0) && (w_acc != '0))) begin
            w_status = hlp_pkg::ST_BAD_COORD;
        end else begin
            // translate a zero start to line 1
            w_os = (w_fin[0] == '0) ? {{(VW-1){1'b0}}, 1'b1} : w_fin[0];
            w_oc = w_fin[1];
            w_ns = (w_fin[2] == '0) ? {{(VW-1){1'b0}}, 1'b1} : w_fin[2];
            w_nc = w_acc;
        end
    end

    // Advance the parser on each byte; drop back to prefix matching after EOL.
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_field = r_field;
        n_acc   = r_acc;
        n_fin   = r_fin;
        n_ovf   = r_ovf;
        n_mal   = r_mal;
        if (w_adv) begin
            if (r_in_eol) begin
                n_phase = hlp_pkg::PH_PREFIX;
                n_pos   = '0;
                n_field = '0;
                n_acc   = '0;
                n_fin   = '{default: '0};
                n_ovf   = 1'b0;
                n_mal   = 1'b0;
            end else begin
                n_phase = w_phase;
                n_pos   = w_pos;
                n_field = w_field;
                n_acc   = w_acc;
                n_fin   = w_fin;
                n_ovf   = w_ovf;
                n_mal   = w_mal;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hlp_pkg::PH_PREFIX;
            r_pos   <= '0;
            r_field <= '0;
            r_acc   <= '0;
            r_fin   <= '{default: '0};
            r_ovf   <= 1'b0;
            r_mal   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_field <= n_field;
            r_acc   <= n_acc;
            r_fin   <= n_fin;
            r_ovf   <= n_ovf;
            r_mal   <= n_mal;
        end
    end

    // ---------------- output register ----------------
    logic                          r_out_valid;
    hlp_pkg::t_status              r_out_status;
    logic [hlp_pkg::OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_eol) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && r_in_eol) begin
            r_out_status <= w_status;
            r_out_data   <= {{(hlp_pkg::OUT_DATA_W - 4*VW){1'b0}}, w_nc, w_ns, w_oc, w_os};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    // ---------------- assertions ----------------
    // A good line always carries nonzero starts.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == hlp_pkg::ST_OK)) |->
        ((r_out_data[VW-1:0] != '0) && (r_out_data[3*VW-1:2*VW] != '0)))
        else $error("ok result with zero start");

    // A failed line carries all-zero coordinates.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != hlp_pkg::ST_OK)) |-> (r_out_data == '0))
        else $error("failed result with nonzero coordinates");

    // Closing a line returns the parser to a clean prefix search.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_eol) |=>
        ((r_phase == hlp_pkg::PH_PREFIX) && (r_pos == '0) && !r_ovf && !r_mal))
        else $error("parser not cleared after end of line");

    // A closing byte always produces a result word in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_eol) |=> r_out_valid)
        else $error("end of line without result");

endmodule

`default_nettype wire
